// ===== design/pu_pkg.sv =====
package pu_pkg;

	localparam int TOTAL_W   = 7;
	localparam int RANK_W    = 21;
	localparam int PART_W    = 7;
	localparam int CNT_W     = 21;
	localparam int MAX_N_DEF = 64;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [RANK_W-1:0]  rank;
	} pu_query_t;

	typedef struct packed {
		logic [PART_W-1:0] part;
		logic              last;
		logic              error;
	} pu_result_t;

	// read request into the count table: entry (row, col)
	typedef struct packed {
		logic              en;
		logic [PART_W-1:0] row;
		logic [PART_W-1:0] col;
	} pu_rd_t;

	typedef enum logic [1:0] {
		TBL_ROW,
		TBL_RD,
		TBL_WR,
		TBL_DONE
	} pu_tbl_state_t;

	typedef enum logic [2:0] {
		PU_IDLE,
		PU_CHECK,
		PU_SCAN,
		PU_CMP,
		PU_EMIT
	} pu_state_t;

endpackage

// ===== design/pu_table.sv =====
module pu_table #(
	parameter int MAX_N = pu_pkg::MAX_N_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pu_pkg::pu_rd_t           rd,
	output logic [pu_pkg::CNT_W-1:0] rd_data,
	output logic                     ready
);
	import pu_pkg::*;

	localparam int DIM   = MAX_N + 1;
	localparam int DEPTH = DIM * DIM;
	localparam int AW    = $clog2(DEPTH);

	logic [CNT_W-1:0] mem [DEPTH];
	logic [CNT_W-1:0] rd_data_q;

	pu_tbl_state_t     state_q, state_d;
	logic [PART_W-1:0] r_q, j_q;
	logic [CNT_W-1:0]  acc_q;
	logic              zero_q;

	logic              wr_en;
	logic [CNT_W-1:0]  wr_data;
	logic [PART_W-1:0] wr_col;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic              rd_en;
	logic [PART_W-1:0] rd_row, rd_col;
	logic              fill_zero;
	logic              row_end;

	// entry (r-j, j) is zero when its minimum part exceeds its total
	assign fill_zero = {j_q, 1'b0} > {1'b0, r_q};
	assign row_end   = (r_q == PART_W'(MAX_N));

	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_data = acc_q + (zero_q ? '0 : rd_data_q);
		wr_col  = j_q;
		rd_en   = rd.en;
		rd_row  = rd.row;
		rd_col  = rd.col;
		case (state_q)
			TBL_ROW: begin
				// diagonal entry (r, r): the single partition r itself
				wr_en   = 1'b1;
				wr_data = CNT_W'(1);
				wr_col  = r_q;
				if (r_q == PART_W'(1)) begin
					state_d = row_end ? TBL_DONE : TBL_ROW;
				end else begin
					state_d = TBL_RD;
				end
			end
			TBL_RD: begin
				rd_en   = !fill_zero;
				rd_row  = r_q - j_q;
				rd_col  = j_q;
				state_d = TBL_WR;
			end
			TBL_WR: begin
				wr_en = 1'b1;
				if (j_q == PART_W'(1)) begin
					state_d = row_end ? TBL_DONE : TBL_ROW;
				end else begin
					state_d = TBL_RD;
				end
			end
			TBL_DONE: ;
			default: state_d = TBL_DONE;
		endcase
	end

	assign wr_addr = AW'(r_q) * AW'(DIM) + AW'(wr_col);
	assign rd_addr = AW'(rd_row) * AW'(DIM) + AW'(rd_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TBL_ROW;
			r_q     <= PART_W'(1);
			j_q     <= PART_W'(1);
		end else begin
			state_q <= state_d;
			case (state_q)
				TBL_ROW: begin
					if (r_q == PART_W'(1)) begin
						r_q <= r_q + PART_W'(1);
					end else begin
						j_q <= r_q - PART_W'(1);
					end
				end
				TBL_WR: begin
					if (j_q == PART_W'(1)) begin
						if (!row_end) r_q <= r_q + PART_W'(1);
					end else begin
						j_q <= j_q - PART_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// running sum along the row and the zero mark of the pending read
	always_ff @(posedge clk) begin
		if (state_q == TBL_ROW) acc_q <= CNT_W'(1);
		if (state_q == TBL_WR) acc_q <= wr_data;
		if (state_q == TBL_RD) zero_q <= fill_zero;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign ready   = (state_q == TBL_DONE);

	a_ready_holds: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ready) |-> ready) else $error("table ready dropped");

	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == TBL_WR |-> $past(state_q) == TBL_RD)
		else $error("fill write without read");

	a_fill_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |-> (j_q <= r_q && r_q <= PART_W'(MAX_N)))
		else $error("fill index out of range");

endmodule

// ===== design/partition_unrank.sv =====
// partition_unrank returns the k-th partition of n (zero-based, parts written in
// nondecreasing order, partitions ordered lexicographically), one part per result
// word, with last set on the final part. A total of zero, a total above MAX_N or
// a rank not below the partition count of n gives a single word with part 0,
// last 1 and error 1. After reset the block builds its count table in one
// synchronous memory and takes no query word until the table is built.
// Queries are then handled one at a time: one table read checks the rank,
// each candidate part examined takes a memory read, then a compare and
// subtract, the final part (always the whole remainder) is taken in the scan
// state without a read, and each part then moves into the output register,
// which output stalls can hold up; an error word skips the scan. The single
// read port of the count table has a registered output, so each read is
// followed by its own compare step. A new query word is taken while the last
// result word still waits in the output register.
module partition_unrank #(
	parameter int MAX_N = pu_pkg::MAX_N_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               query_valid,
	output logic               query_stall,
	input  pu_pkg::pu_query_t  query,
	output logic               result_valid,
	input  logic               result_stall,
	output pu_pkg::pu_result_t result
);
	import pu_pkg::*;

	pu_state_t         state_q, state_d;
	logic [PART_W-1:0] m_q;        // remainder still to partition
	logic [PART_W-1:0] j_q;        // candidate part, starts at previous part
	logic [RANK_W-1:0] k_q;        // rank left within the remainder
	pu_result_t        pend_q;     // word waiting to enter the output register
	pu_result_t        result_q;
	logic              result_valid_q;

	pu_rd_t            rd;
	logic [CNT_W-1:0]  rd_data;
	logic              tbl_ready;

	logic              accept;
	logic              bad_total;
	logic              fits;
	logic              skip;
	logic              out_free;
	logic              out_load;

	pu_table #(.MAX_N(MAX_N)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.rd_data (rd_data),
		.ready   (tbl_ready)
	);

	assign bad_total = (query.total == '0) || (query.total > TOTAL_W'(MAX_N));
	// a candidate below the whole remainder needs room for a second part
	assign fits      = {j_q, 1'b0} <= {1'b0, m_q};
	// rank at or past the count read: move to the next candidate (in the rank check: error)
	assign skip      = {{(RANK_W < CNT_W ? CNT_W - RANK_W : 0){1'b0}}, k_q} >= rd_data;
	assign out_free  = !result_valid_q || !result_stall;
	assign accept    = query_valid && !query_stall;

	// next state and control
	always_comb begin
		state_d     = state_q;
		rd          = '0;
		query_stall = 1'b1;
		out_load    = 1'b0;
		case (state_q)
			PU_IDLE: begin
				query_stall = !tbl_ready;
				if (query_valid && tbl_ready) begin
					if (bad_total) begin
						state_d = PU_EMIT;
					end else begin
						// partition count of n sits at entry (n, 1)
						rd.en   = 1'b1;
						rd.row  = query.total;
						rd.col  = PART_W'(1);
						state_d = PU_CHECK;
					end
				end
			end
			PU_CHECK: begin
				state_d = skip ? PU_EMIT : PU_SCAN;
			end
			PU_SCAN: begin
				if (fits) begin
					// completions of the remainder that start with j
					rd.en   = 1'b1;
					rd.row  = m_q - j_q;
					rd.col  = j_q;
					state_d = PU_CMP;
				end else begin
					// only the whole remainder is left as a candidate
					state_d = PU_EMIT;
				end
			end
			PU_CMP: begin
				state_d = skip ? PU_SCAN : PU_EMIT;
			end
			PU_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = pend_q.last ? PU_IDLE : PU_SCAN;
				end
			end
			default: state_d = PU_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PU_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			PU_IDLE: begin
				if (accept) begin
					m_q    <= query.total;
					k_q    <= query.rank;
					j_q    <= PART_W'(1);
					// error word by default, replaced once a part is picked
					pend_q <= '{part: '0, last: 1'b1, error: 1'b1};
				end
			end
			PU_SCAN: begin
				if (!fits) begin
					pend_q <= '{part: m_q, last: 1'b1, error: 1'b0};
					m_q    <= '0;
				end
			end
			PU_CMP: begin
				if (skip) begin
					k_q <= k_q - RANK_W'(rd_data);
					j_q <= j_q + PART_W'(1);
				end else begin
					// fits held, so the remainder stays above zero
					pend_q <= '{part: j_q, last: 1'b0, error: 1'b0};
					m_q    <= m_q - j_q;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) result_q <= pend_q;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_no_early_query: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> tbl_ready) else $error("query taken during table fill");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == PU_CMP |-> $past(state_q) == PU_SCAN && $past(rd.en))
		else $error("compare without table read");

	a_remainder_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == PU_SCAN |-> m_q != '0) else $error("scan on empty remainder");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error |-> result.last && result.part == '0)
		else $error("malformed error word");

endmodule
